/* hw/rtl/tsw_pkg.sv */
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants for the trace STDP update core
// Holds widths, register indexes and the records passed between the
// front queue and the back update pipeline.
// ----------------------------------------------------------------------------
package tsw_pkg;

   localparam int SYNAPSES = 4096;
   localparam int ADDR_W   = $clog2(SYNAPSES);
   localparam int IDX_W    = 12;
   localparam int DATA_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [DATA_W-1:0] TRACE_ONE = 16'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LTP_GAIN    = 3'd0,
      REG_LTD_GAIN    = 3'd1,
      REG_W_FLOOR     = 3'd2,
      REG_W_CEILING   = 3'd3,
      REG_PRE_DECAY   = 3'd4,
      REG_POST_DECAY  = 3'd5
   } csr_reg_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_LEARN = 1'b1
   } func_type;

   // one classified work item
   typedef struct packed {
      logic                     learn;
      logic [IDX_W-1:0]         idx;
      logic                     pre;
      logic                     post;
      logic signed [DATA_W-1:0] mod;
      logic signed [DATA_W-1:0] load_w;
   } item_type;

   // configuration registers as seen by the pipeline
   typedef struct packed {
      logic [DATA_W-1:0]        ltp_gain;
      logic [DATA_W-1:0]        ltd_gain;
      logic signed [DATA_W-1:0] w_floor;
      logic signed [DATA_W-1:0] w_ceiling;
      logic [DATA_W-1:0]        pre_decay;
      logic [DATA_W-1:0]        post_decay;
   } cfg_type;

   // queue head handshake toward the back pipeline
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

endpackage

/* hw/rtl/trace_stdp_weight_update_core.sv */
// ----------------------------------------------------------------------------
// trace_stdp_weight_update_core: modulated trace STDP synapse updater
// Channel | direction | handshake           | payload
// req_    | in        | start / busy        | func, index, spikes, mod, load
// rsp_    | out       | rsp_valid strobe    | index, new weight, plastic
// csr_    | in        | csr_valid/csr_ready | register index, data
//
// One transaction per cycle while busy is low; each result leaves the queue,
// passes the pipeline registers and then strobes rsp_valid.
// Back-to-back transactions on the same synapse wait for the write-back of
// the earlier one (5-stage read-modify-write loop on the stores).
// Reset clears control state and sets config registers to defaults; stores
// are undefined until loaded. busy rises only when the 4-entry queue is full.
// ----------------------------------------------------------------------------
module trace_stdp_weight_update_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [tsw_pkg::IDX_W-1:0]           req_synapse_index,
   input  logic                                req_pre_spike,
   input  logic                                req_post_spike,
   input  logic signed [tsw_pkg::DATA_W-1:0]   req_modulation,
   input  logic signed [tsw_pkg::DATA_W-1:0]   req_load_weight,
   output logic                                rsp_valid,
   output logic [tsw_pkg::IDX_W-1:0]           rsp_out_index,
   output logic signed [tsw_pkg::DATA_W-1:0]   rsp_new_weight,
   output logic                                rsp_plastic,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsw_pkg::DATA_W-1:0]          csr_wdata
);

   tsw_pkg::cfg_type   cfg_ff;
   tsw_pkg::item_type  req_item;
   tsw_pkg::qhead_type head;
   logic               accept, full, pop;

   assign csr_ready = 1'b1;
   assign busy      = full;
   assign accept    = start && !busy;

   // classify the request
   always_comb begin
      req_item.learn  = (tsw_pkg::func_type'(req_func) == tsw_pkg::FUNC_LEARN);
      req_item.idx    = req_synapse_index;
      req_item.pre    = req_pre_spike;
      req_item.post   = req_post_spike;
      req_item.mod    = req_modulation;
      req_item.load_w = req_load_weight;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ltp_gain   <= 16'd655;
         cfg_ff.ltd_gain   <= 16'd655;
         cfg_ff.w_floor    <= 16'sd0;
         cfg_ff.w_ceiling  <= 16'sd4096;
         cfg_ff.pre_decay  <= 16'd62259;
         cfg_ff.post_decay <= 16'd62259;
      end else if (csr_valid && csr_ready) begin
         case (tsw_pkg::csr_reg_type'(csr_index))
            tsw_pkg::REG_LTP_GAIN:   cfg_ff.ltp_gain   <= csr_wdata;
            tsw_pkg::REG_LTD_GAIN:   cfg_ff.ltd_gain   <= csr_wdata;
            tsw_pkg::REG_W_FLOOR:    cfg_ff.w_floor    <= csr_wdata;
            tsw_pkg::REG_W_CEILING:  cfg_ff.w_ceiling  <= csr_wdata;
            tsw_pkg::REG_PRE_DECAY:  cfg_ff.pre_decay  <= csr_wdata;
            tsw_pkg::REG_POST_DECAY: cfg_ff.post_decay <= csr_wdata;
            default: ;
         endcase
      end
   end

   tsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (req_item),
      .full      (full),
      .head      (head),
      .pop       (pop)
   );

   tsw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .pop         (pop),
      .res_valid   (rsp_valid),
      .res_index   (rsp_out_index),
      .res_weight  (rsp_new_weight),
      .res_plastic (rsp_plastic)
   );

   // no result right after reset
   a_rsp_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result strobe after reset");

   // the queue fills only through an accepted transaction
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(accept)) else $error("busy rose without accept");

   // a learned weight stays within a sane floor and ceiling
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plastic && (cfg_ff.w_floor <= cfg_ff.w_ceiling) |->
      (rsp_new_weight >= cfg_ff.w_floor) && (rsp_new_weight <= cfg_ff.w_ceiling))
      else $error("learned weight outside clamp range");

endmodule

/* hw/rtl/tsw_front.sv */
// ----------------------------------------------------------------------------
// tsw_front: request intake and queue
// Buffers each accepted, already classified transaction in a small queue
// so intake continues while the update pipeline holds off on a hazard.
// ----------------------------------------------------------------------------
module tsw_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  tsw_pkg::item_type                push_item,
   output logic                             full,
   output tsw_pkg::qhead_type               head,
   input  logic                             pop
);

   tsw_pkg::item_type mem_ff [tsw_pkg::QUEUE_DEPTH];
   logic [tsw_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [tsw_pkg::QPTR_W:0]   cnt_ff, cnt_in;
   logic                       do_pop;

   assign full   = (cnt_ff == (tsw_pkg::QPTR_W+1)'(tsw_pkg::QUEUE_DEPTH));
   assign do_pop = pop && (cnt_ff != '0);

   // advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign head = {(cnt_ff != '0), mem_ff[rd_ff]};

endmodule

/* hw/rtl/tsw_back.sv */
// ----------------------------------------------------------------------------
// tsw_back: synapse update pipeline
// Five stages: read stores, decay traces, bump and gain, modulate,
// round/clamp and write back. Issue stalls while the same synapse is
// still in flight.
// ----------------------------------------------------------------------------
module tsw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  tsw_pkg::cfg_type                 cfg,
   input  tsw_pkg::qhead_type               head,
   output logic                             pop,
   output logic                             res_valid,
   output logic [tsw_pkg::IDX_W-1:0]        res_index,
   output logic signed [tsw_pkg::DATA_W-1:0] res_weight,
   output logic                             res_plastic
);

   localparam int DW = tsw_pkg::DATA_W;
   localparam int AW = tsw_pkg::ADDR_W;

   logic signed [DW-1:0] weight_mem [tsw_pkg::SYNAPSES];
   logic [DW-1:0]        pre_mem    [tsw_pkg::SYNAPSES];
   logic [DW-1:0]        post_mem   [tsw_pkg::SYNAPSES];

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   tsw_pkg::item_type it1_ff, it2_ff, it3_ff, it4_ff;

   logic signed [DW-1:0] w_rd_ff;
   logic [DW-1:0]        pt_rd_ff, qt_rd_ff;

   logic signed [DW-1:0] w2_ff, w3_ff, w4_ff;
   logic [DW-1:0]        pt2_ff, qt2_ff, pt3_ff, qt3_ff, pt4_ff, qt4_ff;
   logic [2*DW-1:0]      ltp3_ff, ltd3_ff;
   logic signed [2*DW+DW:0] pp4_ff, pq4_ff;
   logic signed [2*DW+DW:0] pp_mul, pq_mul;

   logic [AW-1:0] a1, a2, a3, a4, ahead;
   logic          hazard;

   logic [2*DW-1:0] pt_dec, qt_dec;
   logic [DW-1:0]   pt_b, qt_b;
   logic            excit;

   logic signed [2*DW+DW+1:0] acc, acc_r;
   logic signed [DW+6:0]      rnd, vsum, vfin;
   logic signed [DW-1:0]      wr_w;
   logic                      wr_plastic;

   assign ahead = head.item.idx[AW-1:0];
   assign a1 = it1_ff.idx[AW-1:0];
   assign a2 = it2_ff.idx[AW-1:0];
   assign a3 = it3_ff.idx[AW-1:0];
   assign a4 = it4_ff.idx[AW-1:0];

   // stall issue while the same entry has an unwritten update in flight
   assign hazard = (v1_ff && a1 == ahead) || (v2_ff && a2 == ahead) ||
                   (v3_ff && a3 == ahead) || (v4_ff && a4 == ahead);
   assign pop    = head.valid && !hazard;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 1: read the stores
   always_ff @(posedge clock) begin
      it1_ff   <= head.item;
      w_rd_ff  <= weight_mem[ahead];
      pt_rd_ff <= pre_mem[ahead];
      qt_rd_ff <= post_mem[ahead];
   end

   // stage 2: decay both traces
   assign pt_dec = pt_rd_ff * cfg.pre_decay;
   assign qt_dec = qt_rd_ff * cfg.post_decay;

   always_ff @(posedge clock) begin
      it2_ff <= it1_ff;
      w2_ff  <= w_rd_ff;
      pt2_ff <= pt_dec[2*DW-1:DW];
      qt2_ff <= qt_dec[2*DW-1:DW];
   end

   // stage 3: spike bump on excitatory synapses, apply gains
   assign excit = !w2_ff[DW-1];

   always_comb begin
      pt_b = pt2_ff;
      qt_b = qt2_ff;
      if (excit && it2_ff.pre) begin
         pt_b = (pt2_ff > ~tsw_pkg::TRACE_ONE) ? '1 : pt2_ff + tsw_pkg::TRACE_ONE;
      end
      if (excit && it2_ff.post) begin
         qt_b = (qt2_ff > ~tsw_pkg::TRACE_ONE) ? '1 : qt2_ff + tsw_pkg::TRACE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      it3_ff  <= it2_ff;
      w3_ff   <= w2_ff;
      pt3_ff  <= pt_b;
      qt3_ff  <= qt_b;
      ltp3_ff <= cfg.ltp_gain * pt_b;
      ltd3_ff <= cfg.ltd_gain * qt_b;
   end

   // stage 4: scale by modulation, drop terms without their spike
   assign pp_mul = $signed({1'b0, ltp3_ff}) * it3_ff.mod;
   assign pq_mul = $signed({1'b0, ltd3_ff}) * it3_ff.mod;

   always_ff @(posedge clock) begin
      it4_ff <= it3_ff;
      w4_ff  <= w3_ff;
      pt4_ff <= pt3_ff;
      qt4_ff <= qt3_ff;
      pp4_ff <= it3_ff.post ? pp_mul : '0;
      pq4_ff <= it3_ff.pre  ? pq_mul : '0;
   end

   // stage 5: round to Q3.12, add, clamp; loads and inhibitory weights bypass
   always_comb begin
      acc   = (2*DW+DW+2)'(pp4_ff) - (2*DW+DW+2)'(pq4_ff);
      acc_r = acc + (2*DW+DW+2)'(64'sd1 << 27);
      rnd   = (DW+7)'($signed(acc_r[2*DW+DW+1:28]));
      vsum  = (DW+7)'(w4_ff) + rnd;
      if (vsum < (DW+7)'(cfg.w_floor)) begin
         vfin = (DW+7)'(cfg.w_floor);
      end else if (vsum > (DW+7)'(cfg.w_ceiling)) begin
         vfin = (DW+7)'(cfg.w_ceiling);
      end else begin
         vfin = vsum;
      end
      if (!it4_ff.learn) begin
         wr_w       = it4_ff.load_w;
         wr_plastic = 1'b0;
      end else if (w4_ff[DW-1]) begin
         wr_w       = w4_ff;
         wr_plastic = 1'b0;
      end else begin
         wr_w       = vfin[DW-1:0];
         wr_plastic = 1'b1;
      end
   end

   // write back
   always_ff @(posedge clock) begin
      if (v4_ff) begin
         weight_mem[a4] <= wr_w;
         pre_mem[a4]    <= it4_ff.learn ? pt4_ff : '0;
         post_mem[a4]   <= it4_ff.learn ? qt4_ff : '0;
      end
   end

   // hold the result for one cycle
   always_ff @(posedge clock) begin
      res_index   <= it4_ff.idx;
      res_weight  <= wr_w;
      res_plastic <= wr_plastic;
   end

   assign res_valid = v5_ff;

endmodule
